>>> sv/pctr_pkg.sv
// ----------------------------------------------------------------------------
// pctr_pkg: shared definitions for the pipe-code text renderer
// Screen limits, character codes, item and result types, and the codes
// that pass between the front and back parts of the renderer.
// ----------------------------------------------------------------------------
package pctr_pkg;

    // Screen limits and tab spacing.
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;
    localparam int TAB_WIDTH   = 8;

    // Cursor column can rest one past the last column and step once more.
    localparam int COL_W     = $clog2(MAX_COLUMNS + 2);
    localparam int ROW_W     = $clog2(MAX_ROWS + 1);
    localparam int TAB_CNT_W = $clog2(TAB_WIDTH + 1);

    // Queue depths between the parts.
    localparam int INQ_DEPTH  = 2;
    localparam int OUTQ_DEPTH = 4;

    // Configuration register indexes and reset values.
    localparam logic CFG_SCREEN_WIDTH = 1'b0;
    localparam logic CFG_SCREEN_LINES = 1'b1;
    localparam logic [7:0] WIDTH_RESET = 8'd80;
    localparam logic [6:0] LINES_RESET = 7'd25;

    // Character codes of interest.
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PIPE  = 8'h7C;

    // Color handling.
    localparam logic [3:0] FG_RESET    = 4'd7;
    localparam logic [6:0] FG_CODE_MAX = 7'd15;

    // Result actions.
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SCROLL = 1'b1;

    // Character classes decided by the front part.
    typedef logic [2:0] char_class_t;
    localparam char_class_t CLS_TEXT = 3'd0;
    localparam char_class_t CLS_BS   = 3'd1;
    localparam char_class_t CLS_CR   = 3'd2;
    localparam char_class_t CLS_LF   = 3'd3;
    localparam char_class_t CLS_TAB  = 3'd4;
    localparam char_class_t CLS_PIPE = 3'd5;

    // One input beat.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic       action;
        logic [6:0] column;
        logic [5:0] row;
        logic [7:0] glyph;
        logic [7:0] attribute;
        logic       last_result;
    } out_item_t;

    // An input beat after classification.
    typedef struct packed {
        in_item_t    item;
        logic        is_digit;
        char_class_t cls;
    } cls_item_t;

    // Head of the front queue as seen by the back part.
    typedef struct packed {
        logic      avail;
        cls_item_t data;
    } front_link_t;

endpackage

>>> sv/pipe_code_text_renderer_unit.sv
// ----------------------------------------------------------------------------
// pipe_code_text_renderer_unit: text stream to screen cell writes
// Turns a byte stream with '|' color codes into cell writes and scrolls.
//
// Input: a beat is taken when push is high and full is low; it carries one
// text byte and an end-of-text flag. Results: while empty is low the oldest
// result is on the result port, and pop takes it. The last result caused by
// a byte has last_result set; a byte may cause none.
// Configuration: cfg_index 0 is the screen width, 1 the line count; writes
// are taken every cycle (cfg_ready is tied high) and belong between texts.
// Sequencer: an ordinary byte is taken and sorted, then its cell is written;
// a tab writes its spaces one at a time, a wrap that scrolls adds a scroll
// step, and a flushed code gives its results one at a time. No new byte is
// taken until the last one is done. A result passes from the input queue
// through the item register and the one-result hold into the result queue.
// A two-entry queue ahead of the sequencer and a four-entry result queue
// behind it let input and output stall apart; when the receiver stops,
// the result queue fills, the sequencer holds, then full rises.
// Reset: cursor at the top left, foreground 7 on background 0, no pending
// code, an 80 by 25 screen, both queues empty.
// ----------------------------------------------------------------------------
module pipe_code_text_renderer_unit
    import pctr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   item,
    output logic       empty,
    input  logic       pop,
    output out_item_t  result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0]       width_cfg_reg, width_cfg_next;
    logic [6:0]       lines_cfg_reg, lines_cfg_next;
    logic [COL_W-1:0] width_eff;
    logic [ROW_W-1:0] lines_eff;
    front_link_t      link;
    logic             back_pop;
    logic             outq_full;
    logic             outq_push;
    out_item_t        outq_data;

    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_comb
    begin
        width_cfg_next = width_cfg_reg;
        lines_cfg_next = lines_cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH: width_cfg_next = cfg_data;
                CFG_SCREEN_LINES: lines_cfg_next = cfg_data[6:0];
                default:          width_cfg_next = width_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg <= WIDTH_RESET;
            lines_cfg_reg <= LINES_RESET;
        end
        else
        begin
            width_cfg_reg <= width_cfg_next;
            lines_cfg_reg <= lines_cfg_next;
        end
    end

    // Screen size as used, held to one up to the limits.
    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            width_eff = COL_W'(1);
        end
        else if ({1'b0, width_cfg_reg} > 9'(MAX_COLUMNS))
        begin
            width_eff = COL_W'(MAX_COLUMNS);
        end
        else
        begin
            width_eff = COL_W'(width_cfg_reg);
        end

        if (lines_cfg_reg == '0)
        begin
            lines_eff = ROW_W'(1);
        end
        else if ({1'b0, lines_cfg_reg} > 8'(MAX_ROWS))
        begin
            lines_eff = ROW_W'(MAX_ROWS);
        end
        else
        begin
            lines_eff = ROW_W'(lines_cfg_reg);
        end
    end

    pctr_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .pop   (back_pop),
        .link  (link)
    );

    pctr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .link      (link),
        .pop       (back_pop),
        .width_eff (width_eff),
        .lines_eff (lines_eff),
        .outq_full (outq_full),
        .outq_push (outq_push),
        .outq_data (outq_data)
    );

    pctr_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (outq_push),
        .wdata (outq_data),
        .full  (outq_full),
        .rd    (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

>>> sv/pctr_front.sv
// ----------------------------------------------------------------------------
// pctr_front: input classifier and queue
// Accepts text beats, tags each with its character class and a digit flag,
// and holds them in a short queue for the back part.
// ----------------------------------------------------------------------------
module pctr_front
    import pctr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    input  logic        pop,
    output front_link_t link
);

    localparam int PTR_W = $clog2(INQ_DEPTH);
    localparam int CNT_W = $clog2(INQ_DEPTH + 1);

    cls_item_t          q_mem [INQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;
    cls_item_t          entry;

    // Sort a byte into the classes that the back part treats apart.
    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t k;
        case (c)
            CHAR_BS:   k = CLS_BS;
            CHAR_CR:   k = CLS_CR;
            CHAR_LF:   k = CLS_LF;
            CHAR_TAB:  k = CLS_TAB;
            CHAR_PIPE: k = CLS_PIPE;
            default:   k = CLS_TEXT;
        endcase
        return k;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(INQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Classification of the incoming beat.
    assign entry.item     = item;
    assign entry.is_digit = item.char_code inside {[CHAR_ZERO:CHAR_NINE]};
    assign entry.cls      = classify(item.char_code);

    assign full    = (count_reg == CNT_W'(INQ_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign link.avail = (count_reg != '0);
    assign link.data  = q_mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

`ifndef SYNTH
    // The back part only takes a beat that is there.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> link.avail)
        else $error("front queue popped while empty");
`endif

endmodule

>>> sv/pctr_back.sv
// ----------------------------------------------------------------------------
// pctr_back: cursor, color and code sequencer
// Runs classified beats one micro-step per cycle while the result queue takes
// results; keeps cursor, colors and pending pipe code; one result per cycle at most.
// ----------------------------------------------------------------------------
module pctr_back
    import pctr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  front_link_t      link,
    output logic             pop,
    input  logic [COL_W-1:0] width_eff,
    input  logic [ROW_W-1:0] lines_eff,
    input  logic             outq_full,
    output logic             outq_push,
    output out_item_t        outq_data
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FPIPE  = 3'd1;
    localparam logic [2:0] ST_FWRAP  = 3'd2;
    localparam logic [2:0] ST_FDIGIT = 3'd3;
    localparam logic [2:0] ST_FRESH  = 3'd4;
    localparam logic [2:0] ST_GLYPH  = 3'd5;
    localparam logic [2:0] ST_TAB    = 3'd6;
    localparam logic [2:0] ST_LF     = 3'd7;

    // Pipe code phases.
    localparam logic [1:0] PH_NONE  = 2'd0;
    localparam logic [1:0] PH_BAR   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    logic [2:0]           state_reg, state_next;
    cls_item_t            item_reg, item_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [3:0]           fg_reg, fg_next;
    logic [3:0]           bg_reg, bg_next;
    logic [1:0]           phase_reg, phase_next;
    logic [7:0]           held_reg, held_next;
    logic                 fresh_pend_reg, fresh_pend_next;
    logic [TAB_CNT_W-1:0] tab_cnt_reg, tab_cnt_next;
    out_item_t            hold_reg, hold_next;
    logic                 hold_valid_reg, hold_valid_next;

    logic                 advance;
    logic                 emit;
    out_item_t            res;
    logic                 final_op;
    logic                 act_en;
    logic                 flush_done;
    logic                 fresh_done;
    logic                 hold_push;

    logic                 wrap_hit, wrap_scroll, lf_scroll;
    logic [COL_W-1:0]     wr_col, wr_col_inc;
    logic [ROW_W-1:0]     wr_row, row_inc, lf_inc, last_row;
    logic [7:0]           attr;
    logic [6:0]           code;

    function automatic out_item_t make_write(input logic [COL_W-1:0] c,
                                             input logic [ROW_W-1:0] r,
                                             input logic [7:0] g,
                                             input logic [7:0] a);
        out_item_t o;
        o.action      = ACT_WRITE;
        o.column      = c[6:0];
        o.row         = r[5:0];
        o.glyph       = g;
        o.attribute   = a;
        o.last_result = 1'b0;
        return o;
    endfunction

    function automatic out_item_t make_scroll();
        out_item_t o;
        o             = '0;
        o.action      = ACT_SCROLL;
        return o;
    endfunction

    // The back part moves on unless a finished result cannot leave.
    assign advance = !(hold_valid_reg && outq_full);

    // Lazy wrap of the current cursor and the line feed from there.
    assign last_row    = lines_eff - ROW_W'(1);
    assign row_inc     = row_reg + ROW_W'(1);
    assign wrap_hit    = (col_reg >= width_eff);
    assign wrap_scroll = wrap_hit && (row_inc >= lines_eff);
    assign wr_col      = wrap_hit ? '0 : col_reg;
    assign wr_row      = wrap_hit ? (wrap_scroll ? last_row : row_inc) : row_reg;
    assign wr_col_inc  = wr_col + COL_W'(1);
    assign lf_inc      = wr_row + ROW_W'(1);
    assign lf_scroll   = (lf_inc >= lines_eff);

    // Current attribute and the two-digit color code.
    assign attr = {bg_reg, fg_reg};
    assign code = 7'({held_reg[3:0], 3'b000}) + 7'({held_reg[3:0], 1'b0})
                + 7'(link.data.item.char_code[3:0]);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        fg_next         = fg_reg;
        bg_next         = bg_reg;
        phase_next      = phase_reg;
        held_next       = held_reg;
        fresh_pend_next = fresh_pend_reg;
        tab_cnt_next    = tab_cnt_reg;
        pop             = 1'b0;
        emit            = 1'b0;
        res             = '0;
        final_op        = 1'b0;
        act_en          = 1'b0;
        flush_done      = 1'b0;
        fresh_done      = 1'b0;

        if (advance)
        begin
            case (state_reg)
                // Take a beat, pull the row inside the screen and sort it out.
                ST_IDLE:
                begin
                    if (link.avail)
                    begin
                        pop          = 1'b1;
                        item_next    = link.data;
                        tab_cnt_next = '0;
                        if (row_reg >= lines_eff)
                        begin
                            row_next = last_row;
                        end
                        if ((phase_reg != PH_NONE) && link.data.is_digit)
                        begin
                            if (phase_reg == PH_BAR)
                            begin
                                held_next  = link.data.item.char_code;
                                phase_next = PH_DIGIT;
                                if (link.data.item.end_of_text)
                                begin
                                    state_next = ST_FPIPE;
                                end
                                else
                                begin
                                    final_op = 1'b1;
                                end
                            end
                            else
                            begin
                                phase_next = PH_NONE;
                                if (code > FG_CODE_MAX)
                                begin
                                    bg_next = code[3:0];
                                end
                                else
                                begin
                                    fg_next = code[3:0];
                                end
                                final_op = 1'b1;
                            end
                        end
                        else if (phase_reg != PH_NONE)
                        begin
                            fresh_pend_next = 1'b1;
                            state_next      = ST_FPIPE;
                        end
                        else
                        begin
                            state_next = ST_FRESH;
                        end
                    end
                end

                // Print the bar of an unfinished code.
                ST_FPIPE:
                begin
                    emit     = 1'b1;
                    res      = make_write(col_reg, row_reg, CHAR_PIPE, attr);
                    col_next = col_reg + COL_W'(1);
                    if (phase_reg == PH_DIGIT)
                    begin
                        state_next = ST_FWRAP;
                    end
                    else
                    begin
                        phase_next = PH_NONE;
                        flush_done = 1'b1;
                    end
                end

                // Wrap before the held digit; print it at once if no scroll.
                ST_FWRAP:
                begin
                    emit     = 1'b1;
                    row_next = wr_row;
                    if (wrap_scroll)
                    begin
                        res        = make_scroll();
                        col_next   = wr_col;
                        state_next = ST_FDIGIT;
                    end
                    else
                    begin
                        res        = make_write(wr_col, wr_row, held_reg, attr);
                        col_next   = wr_col_inc;
                        phase_next = PH_NONE;
                        flush_done = 1'b1;
                    end
                end

                ST_FDIGIT:
                begin
                    emit       = 1'b1;
                    res        = make_write(col_reg, row_reg, held_reg, attr);
                    col_next   = col_reg + COL_W'(1);
                    phase_next = PH_NONE;
                    flush_done = 1'b1;
                end

                // A byte handled as fresh text.
                ST_FRESH:
                begin
                    case (item_reg.cls)
                        CLS_BS:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - COL_W'(1);
                            end
                            fresh_done = 1'b1;
                        end
                        CLS_CR:
                        begin
                            col_next   = '0;
                            fresh_done = 1'b1;
                        end
                        default:
                        begin
                            if (wrap_scroll)
                            begin
                                emit     = 1'b1;
                                res      = make_scroll();
                                col_next = wr_col;
                                row_next = wr_row;
                                case (item_reg.cls)
                                    CLS_PIPE:
                                    begin
                                        phase_next = PH_BAR;
                                        fresh_done = 1'b1;
                                    end
                                    CLS_LF:  state_next = ST_LF;
                                    CLS_TAB: state_next = ST_TAB;
                                    default: state_next = ST_GLYPH;
                                endcase
                            end
                            else
                            begin
                                act_en = 1'b1;
                            end
                        end
                    endcase
                end

                ST_GLYPH, ST_TAB, ST_LF:
                begin
                    act_en = 1'b1;
                end

                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase

            // The action of a fresh byte from the wrapped cursor.
            if (act_en)
            begin
                case (item_reg.cls)
                    CLS_PIPE:
                    begin
                        col_next   = wr_col;
                        row_next   = wr_row;
                        phase_next = PH_BAR;
                        fresh_done = 1'b1;
                    end
                    CLS_LF:
                    begin
                        col_next = '0;
                        if (lf_scroll)
                        begin
                            emit     = 1'b1;
                            res      = make_scroll();
                            row_next = last_row;
                        end
                        else
                        begin
                            row_next = lf_inc;
                        end
                        fresh_done = 1'b1;
                    end
                    CLS_TAB:
                    begin
                        emit         = 1'b1;
                        res          = make_write(wr_col, wr_row, CHAR_SPACE, attr);
                        col_next     = wr_col_inc;
                        row_next     = wr_row;
                        tab_cnt_next = tab_cnt_reg + TAB_CNT_W'(1);
                        if ((tab_cnt_next < TAB_CNT_W'(TAB_WIDTH))
                            && (wr_col_inc < width_eff))
                        begin
                            state_next = ST_TAB;
                        end
                        else
                        begin
                            fresh_done = 1'b1;
                        end
                    end
                    default:
                    begin
                        emit     = 1'b1;
                        res      = make_write(wr_col, wr_row, item_reg.item.char_code,
                                              attr);
                        col_next = wr_col_inc;
                        row_next = wr_row;
                        fresh_done = 1'b1;
                    end
                endcase
            end

            // After a flush, either go on to the byte or end the beat.
            if (flush_done)
            begin
                if (fresh_pend_reg)
                begin
                    fresh_pend_next = 1'b0;
                    state_next      = ST_FRESH;
                end
                else
                begin
                    state_next = ST_IDLE;
                    final_op   = 1'b1;
                end
            end

            // After the byte, an end of text flushes a bar just seen.
            if (fresh_done)
            begin
                if (item_reg.item.end_of_text && (item_reg.cls == CLS_PIPE))
                begin
                    state_next = ST_FPIPE;
                end
                else
                begin
                    state_next = ST_IDLE;
                    final_op   = 1'b1;
                end
            end
        end
    end

    // One-result hold: a result leaves once the next one exists or the
    // beat is known to be over, so the last one can be marked.
    always_comb
    begin
        hold_push       = advance && hold_valid_reg && (hold_reg.last_result || emit);
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        if (emit)
        begin
            hold_next             = res;
            hold_next.last_result = final_op;
            hold_valid_next       = 1'b1;
        end
        else if (hold_push)
        begin
            hold_valid_next = 1'b0;
        end
        else if (final_op && hold_valid_reg)
        begin
            hold_next.last_result = 1'b1;
        end
    end

    assign outq_push = hold_push;
    assign outq_data = hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            fg_reg         <= FG_RESET;
            bg_reg         <= '0;
            phase_reg      <= PH_NONE;
            held_reg       <= '0;
            fresh_pend_reg <= 1'b0;
            tab_cnt_reg    <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            fg_reg         <= fg_next;
            bg_reg         <= bg_next;
            phase_reg      <= phase_next;
            held_reg       <= held_next;
            fresh_pend_reg <= fresh_pend_next;
            tab_cnt_reg    <= tab_cnt_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        hold_reg <= hold_next;
    end

`ifndef SYNTH
    // A tab never runs past its width of spaces.
    a_tab_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAB) |-> (tab_cnt_reg < TAB_CNT_W'(TAB_WIDTH)))
        else $error("tab space count out of range");

    // The wrap before a held digit only happens with a digit held.
    a_fwrap_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FWRAP) |-> (phase_reg == PH_DIGIT))
        else $error("digit flush without a held digit");

    // Between beats, a waiting result is always marked as the last one.
    a_hold_marked: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && hold_valid_reg) |-> hold_reg.last_result)
        else $error("unmarked result left over from a finished beat");
`endif

endmodule

>>> sv/pctr_outq.sv
// ----------------------------------------------------------------------------
// pctr_outq: result queue
// Holds finished results until the receiver pops them, so the back part
// can keep working while the receiver stalls.
// ----------------------------------------------------------------------------
module pctr_outq
    import pctr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  out_item_t wdata,
    output logic      full,
    input  logic      rd,
    output out_item_t rdata,
    output logic      empty
);

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    out_item_t        q_mem [OUTQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full  = (count_reg == CNT_W'(OUTQ_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = q_mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_wr ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_mem[wr_ptr_reg] <= wdata;
        end
    end

`ifndef SYNTH
    // The back part never offers a result that would be dropped.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> !full)
        else $error("result pushed into a full queue");
`endif

endmodule
